// ----- hdl/tvmd_pkg.sv -----
// Shared types and codes for the tagged varint message decoder.
// No dependencies; imported by tagged_varint_message_decoder_unit.
`timescale 1ns / 1ps

package tvmd_pkg;

    // Decoder phase, one-hot
    typedef enum logic [5:0] {
        PH_CODE    = 6'b000001,
        PH_KIND    = 6'b000010,
        PH_GROUPS  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_TERM    = 6'b010000,
        PH_HALT    = 6'b100000
    } phase_t;

    // Result event codes
    localparam logic [1:0] EV_ARG     = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    // Reported argument kinds
    localparam logic [1:0] KD_NULL = 2'd0;
    localparam logic [1:0] KD_POS  = 2'd1;
    localparam logic [1:0] KD_NEG  = 2'd2;
    localparam logic [1:0] KD_STR  = 2'd3;

    // Kind bytes on the wire
    localparam logic [7:0] KB_END  = 8'd0;
    localparam logic [7:0] KB_STR  = 8'd1;
    localparam logic [7:0] KB_POS  = 8'd2;
    localparam logic [7:0] KB_NEG  = 8'd3;
    localparam logic [7:0] KB_NULL = 8'd4;

    // Varint group fields
    localparam logic [7:0] GRP_LAST_MASK = 8'h80;
    localparam logic [7:0] GRP_DATA_MASK = 8'h7f;
    localparam int unsigned MAX_GROUPS   = 9;
    localparam int unsigned GRP_BITS     = 7;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [7:0]         message_code;
        logic [4:0]         arg_index;
        logic [1:0]         arg_tag;
        logic signed [63:0] arg_value;
        logic [7:0]         payload_byte;
    } res_t;

endpackage

// ----- hdl/tagged_varint_message_decoder_unit.sv -----
// Tagged varint message decoder: byte stream in, argument/payload/end events out.
// Depends on tvmd_pkg (phase type, event and kind codes, result struct).
// A result is registered in the output register, or in the skid if the output stalls.
// Throughput: one byte per cycle; a two-entry output buffer (result + skid) absorbs one
// more result while the output is stalled, then s_ready drops until the skid drains.
// Reset (aresetn low, synchronous): phase returns to expect-code, counters clear,
// output buffer empties. An error halts decoding until the next reset.
`timescale 1ns / 1ps

module tagged_varint_message_decoder_unit
    import tvmd_pkg::*;
#(
    parameter int unsigned MAX_ARGS = 20
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_event_res,
    output logic [7:0]         m_message_code,
    output logic [4:0]         m_arg_index,
    output logic [1:0]         m_arg_tag,
    output logic signed [63:0] m_arg_value,
    output logic [7:0]         m_payload_byte
);

    localparam logic [4:0] ARG_LIMIT = 5'(MAX_ARGS);

    // ---------------- decoder state ----------------
    phase_t      phase_reg,     phase_next;
    logic [63:0] acc_reg,       acc_next;
    logic [3:0]  grp_cnt_reg,   grp_cnt_next;   // groups taken so far
    logic [1:0]  kind_reg,      kind_next;
    logic [63:0] remain_reg,    remain_next;    // payload bytes still to come
    logic [7:0]  code_reg,      code_next;
    logic [4:0]  arg_cnt_reg,   arg_cnt_next;

    // ---------------- output buffer ----------------
    res_t out_reg,  out_next;
    logic out_valid_reg, out_valid_next;
    res_t skid_reg, skid_next;
    logic skid_valid_reg, skid_valid_next;

    logic in_take;
    logic pop;
    logic have_res;
    res_t res;

    // group insertion and final value
    logic [5:0]  grp_shift;
    logic [63:0] acc_merged;
    logic        grp_last;

    assign s_ready = !skid_valid_reg;
    assign in_take = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    // Group n lands at bit 7n; at most 9 groups so the shift stays below 64.
    assign grp_shift  = 6'({2'b00, grp_cnt_reg} * 6'(GRP_BITS));
    assign acc_merged = acc_reg | (64'(s_in_byte & GRP_DATA_MASK) << grp_shift);
    assign grp_last   = (s_in_byte & GRP_LAST_MASK) != 8'h00;

    // ---------------- per-byte decode ----------------
    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        grp_cnt_next = grp_cnt_reg;
        kind_next    = kind_reg;
        remain_next  = remain_reg;
        code_next    = code_reg;
        arg_cnt_next = arg_cnt_reg;

        have_res         = 1'b0;
        res.event_res    = EV_ARG;
        res.message_code = code_reg;
        res.arg_index    = arg_cnt_reg;
        res.arg_tag      = KD_NULL;
        res.arg_value    = '0;
        res.payload_byte = 8'h00;

        unique case (phase_reg)
            PH_CODE: begin
                code_next    = s_in_byte;
                arg_cnt_next = '0;
                phase_next   = PH_KIND;
            end
            PH_KIND: begin
                if (s_in_byte == KB_END) begin
                    have_res      = 1'b1;
                    res.event_res = EV_END;
                    phase_next    = PH_CODE;
                end else if (s_in_byte > KB_NULL || arg_cnt_reg >= ARG_LIMIT) begin
                    // unknown kind or argument overflow
                    have_res         = 1'b1;
                    res.event_res    = EV_ERROR;
                    res.payload_byte = s_in_byte;
                    phase_next       = PH_HALT;
                end else if (s_in_byte == KB_NULL) begin
                    have_res     = 1'b1;
                    res.arg_tag  = KD_NULL;
                    arg_cnt_next = arg_cnt_reg + 5'd1;
                end else begin
                    case (s_in_byte)
                        KB_STR:  kind_next = KD_STR;
                        KB_POS:  kind_next = KD_POS;
                        default: kind_next = KD_NEG;
                    endcase
                    acc_next     = '0;
                    grp_cnt_next = '0;
                    phase_next   = PH_GROUPS;
                end
            end
            PH_GROUPS: begin
                if (grp_cnt_reg >= 4'(MAX_GROUPS)) begin
                    // tenth group: value would pass 63 bits
                    have_res         = 1'b1;
                    res.event_res    = EV_ERROR;
                    res.payload_byte = s_in_byte;
                    phase_next       = PH_HALT;
                end else begin
                    acc_next     = acc_merged;
                    grp_cnt_next = grp_cnt_reg + 4'd1;
                    if (grp_last) begin
                        have_res      = 1'b1;
                        res.arg_tag   = kind_reg;
                        res.arg_value = (kind_reg == KD_NEG) ? -$signed(acc_merged)
                                                             : $signed(acc_merged);
                        arg_cnt_next  = arg_cnt_reg + 5'd1;
                        if (kind_reg == KD_STR) begin
                            remain_next = acc_merged;
                            phase_next  = (acc_merged == 64'd0) ? PH_TERM : PH_PAYLOAD;
                        end else begin
                            phase_next  = PH_KIND;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                have_res         = 1'b1;
                res.event_res    = EV_PAYLOAD;
                res.arg_index    = arg_cnt_reg - 5'd1;
                res.arg_tag      = KD_STR;
                res.payload_byte = s_in_byte;
                remain_next      = remain_reg - 64'd1;
                if (remain_reg == 64'd1) begin
                    phase_next = PH_TERM;
                end
            end
            PH_TERM: begin
                // terminator byte skipped, whatever it holds
                phase_next = PH_KIND;
            end
            PH_HALT: begin
                phase_next = PH_HALT;
            end
            default: begin
                phase_next = PH_HALT;
            end
        endcase
    end

    // ---------------- output buffer control ----------------
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg) begin
            // input is held off while skid is full
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_take && have_res) begin
            if (!out_valid_reg || pop) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_CODE;
            acc_reg        <= '0;
            grp_cnt_reg    <= '0;
            kind_reg       <= KD_NULL;
            remain_reg     <= '0;
            code_reg       <= '0;
            arg_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                grp_cnt_reg <= grp_cnt_next;
                kind_reg    <= kind_next;
                remain_reg  <= remain_next;
                code_reg    <= code_next;
                arg_cnt_reg <= arg_cnt_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_event_res    = out_reg.event_res;
    assign m_message_code = out_reg.message_code;
    assign m_arg_index    = out_reg.arg_index;
    assign m_arg_tag      = out_reg.arg_tag;
    assign m_arg_value    = out_reg.arg_value;
    assign m_payload_byte = out_reg.payload_byte;

endmodule
